>>> hdl/websocket_frame_deframer_defines.svh
// Assertion macros shared by the deframer RTL files.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("deframer assertion failed");

// Checks a property on every rising clock edge, reset included.
`define WSD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("deframer assertion failed");

`else

`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/wsd_pkg.sv
// Types and constants shared by the deframer modules.
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5,
        PH_DEAD  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam int unsigned KEY_BYTES = 4;
    localparam int unsigned KEY_IDX_W = 2;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // One classified item handed from the parser to the output side.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] key;
        kind_t      kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } wsd_cmd_t;

endpackage

>>> hdl/wsd_front.sv
// Header parser: tracks frame state and classifies each received byte.
`timescale 1ns / 1ps

module wsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              q_ready,
    input  logic [7:0]        s_tdata,
    output logic              push,
    output wsd_pkg::wsd_cmd_t push_cmd
);
    import wsd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic [3:0]             op_reg, op_next;
    logic                   masked_reg, masked_next;
    logic [15:0]            rem_reg, rem_next;
    logic [7:0]             key_reg [KEY_BYTES];
    logic [7:0]             key_next [KEY_BYTES];
    logic [KEY_IDX_W-1:0]   cnt_reg, cnt_next;

    logic                   fire;
    logic [6:0]             len7;
    logic [15:0]            ext_len;
    logic [15:0]            rem_dec;
    logic [KEY_IDX_W-1:0]   cnt_inc;

    assign fire    = s_tvalid & q_ready;
    assign len7    = s_tdata[6:0];
    assign ext_len = {rem_reg[15:8], s_tdata};
    assign rem_dec = rem_reg - 16'd1;
    assign cnt_inc = cnt_reg + KEY_IDX_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        for (int i = 0; i < KEY_BYTES; i++) begin
            key_next[i] = key_reg[i];
        end
        if (fire) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next   = s_tdata[7];
                    op_next    = s_tdata[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = s_tdata[7];
                    if (len7 == LEN_CODE_64) begin
                        phase_next = PH_DEAD;
                    end else if (len7 == LEN_CODE_16) begin
                        phase_next = PH_EXTHI;
                    end else begin
                        rem_next = {9'd0, len7};
                        cnt_next = '0;
                        if (s_tdata[7]) begin
                            phase_next = PH_MASK;
                        end else if (len7 == 7'd0) begin
                            phase_next = PH_HDR0;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_EXTHI: begin
                    rem_next   = {s_tdata, 8'h00};
                    phase_next = PH_EXTLO;
                end
                PH_EXTLO: begin
                    rem_next = ext_len;
                    cnt_next = '0;
                    if (masked_reg) begin
                        phase_next = PH_MASK;
                    end else if (ext_len == 16'd0) begin
                        phase_next = PH_HDR0;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_MASK: begin
                    key_next[cnt_reg] = s_tdata;
                    cnt_next          = cnt_inc;
                    if (cnt_inc == '0) begin
                        phase_next = (rem_reg == 16'd0) ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    cnt_next = cnt_inc;
                    rem_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    // Discard state after an unsupported length: bytes are dropped.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        push            = 1'b0;
        push_cmd.raw    = 8'h00;
        push_cmd.key    = 8'h00;
        push_cmd.kind   = KIND_EMPTY;
        push_cmd.opcode = op_reg;
        push_cmd.fin    = fin_reg;
        push_cmd.last   = 1'b1;
        if (fire) begin
            case (phase_reg)
                PH_HDR1: begin
                    if (len7 == LEN_CODE_64) begin
                        push          = 1'b1;
                        push_cmd.kind = KIND_ERROR;
                    end else if (len7 != LEN_CODE_16 && !s_tdata[7] && len7 == 7'd0) begin
                        push = 1'b1;
                    end
                end
                PH_EXTLO: begin
                    push = !masked_reg && ext_len == 16'd0;
                end
                PH_MASK: begin
                    push = cnt_inc == '0 && rem_reg == 16'd0;
                end
                PH_DATA: begin
                    push          = 1'b1;
                    push_cmd.raw  = s_tdata;
                    push_cmd.key  = masked_reg ? key_reg[cnt_reg] : 8'h00;
                    push_cmd.kind = KIND_DATA;
                    push_cmd.last = rem_dec == 16'd0;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            op_reg     <= 4'd0;
            masked_reg <= 1'b0;
            rem_reg    <= 16'd0;
            cnt_reg    <= '0;
            for (int i = 0; i < KEY_BYTES; i++) begin
                key_reg[i] <= 8'h00;
            end
        end else begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            for (int i = 0; i < KEY_BYTES; i++) begin
                key_reg[i] <= key_next[i];
            end
        end
    end

endmodule

>>> hdl/wsd_queue.sv
// Small FIFO between the header parser and the output stage.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wsd_pkg::wsd_cmd_t push_cmd,
    output logic              ready,
    input  logic              pop,
    output logic              valid,
    output wsd_pkg::wsd_cmd_t pop_cmd
);
    import wsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsd_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready   = count_reg != CNT_FULL;
    assign valid   = count_reg != '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `WSD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_FULL)
    `WSD_ASSERT(a_no_overflow, aclk, aresetn, !(push && !pop && count_reg == CNT_FULL))
    `WSD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && count_reg == '0))

endmodule

>>> hdl/wsd_back.sv
// Output stage: unmasks payload bytes and holds each result until taken.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module wsd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  wsd_pkg::wsd_cmd_t q_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    kind_t      kind_reg;
    logic [3:0] op_reg;
    logic       fin_reg;
    logic       last_reg;
    logic       valid_next;

    assign pop        = q_valid && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Non-payload items carry a zero key and zero raw byte, so the XOR leaves zero.
    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= q_cmd.raw ^ q_cmd.key;
            kind_reg <= q_cmd.kind;
            op_reg   <= q_cmd.opcode;
            fin_reg  <= q_cmd.fin;
            last_reg <= q_cmd.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, fin_reg, op_reg, data_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    `WSD_ASSERT(a_single_last, aclk, aresetn,
        (valid_reg && kind_reg != KIND_DATA) |-> last_reg)
    `WSD_ASSERT(a_single_zero, aclk, aresetn,
        (valid_reg && kind_reg != KIND_DATA) |-> (data_reg == 8'h00))
    `WSD_ASSERT(a_error_ends, aclk, aresetn,
        (valid_reg && m_tready && kind_reg == KIND_ERROR) |=> !valid_reg)

endmodule

>>> hdl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
`timescale 1ns / 1ps

// Takes a received WebSocket stream one byte per item on the s_ channel and
// gives one result item per payload byte on the m_ channel, unmasked with the
// frame's rotating key, with m_tlast on the final byte of each frame. A frame
// of length zero gives a single empty-frame item, and a 64-bit length gives
// one error item, after which all input is dropped until reset. Other header
// bytes give no result. The block takes one byte every cycle; the only stall
// on the input comes from the QUEUE_DEPTH-entry queue filling while the m_
// side holds m_tready low. Each result passes through the queue and then the
// output register before it appears on the m_ channel.
module websocket_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [11:8] frame_opcode, [12] final_frame
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import wsd_pkg::*;

    logic     q_ready;
    logic     push;
    wsd_cmd_t push_cmd;
    logic     q_valid;
    logic     pop;
    wsd_cmd_t pop_cmd;

    assign s_tready = q_ready;

    wsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .q_ready  (q_ready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> test/websocket_frame_deframer_test.sv
// Self-checking testbench for the WebSocket frame deframer: directed table, random frames, idling.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
    import wsd_pkg::*;

    // Frame opcodes used by the directed table.
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_RSVD_F = 4'hF;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned DIR_MAIN     = 25;
    localparam int unsigned DIR_ROWS     = 30;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } frame_item_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        frame_item_t res;
    } dir_row_t;

    localparam frame_item_t NO_ITEM = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] data_byte, [11:8] frame_opcode, [12] final_frame
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;

    websocket_frame_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the parser state.
    phase_t      rx_phase = PH_HDR0;
    logic        rx_fin = 1'b0;
    logic [3:0]  rx_opcode = 4'h0;
    logic        rx_masked = 1'b0;
    logic [15:0] rx_remaining = 16'h0000;
    logic [7:0]  rx_key [KEY_BYTES] = '{default: 8'h00};
    logic [1:0]  rx_key_idx = 2'd0;

    frame_item_t deframed_q [$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned n_fail = 0;
    int unsigned n_bytes = 0;
    int unsigned n_frames = 0;
    int unsigned n_results = 0;
    int unsigned n_empty = 0;
    int unsigned stall_cycles = 0;

    // The directed rows: empty ping, reserved bits with opcode F and extreme payload,
    // masked text, big-endian extended length, extended length of zero, then the
    // 64-bit length error and bytes that must be dropped after it.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{{1'b1, 3'b000, OP_PING}, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, '{8'h00, KIND_EMPTY, OP_PING, 1'b1, 1'b1}},
        '{{1'b0, 3'b111, OP_RSVD_F}, 1'b0, NO_ITEM},
        '{8'h02, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, '{8'h00, KIND_DATA, OP_RSVD_F, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, KIND_DATA, OP_RSVD_F, 1'b0, 1'b1}},
        '{{1'b1, 3'b000, OP_TEXT}, 1'b0, NO_ITEM},
        '{8'h82, 1'b0, NO_ITEM},
        '{8'h37, 1'b0, NO_ITEM},
        '{8'hFA, 1'b0, NO_ITEM},
        '{8'h21, 1'b0, NO_ITEM},
        '{8'h3D, 1'b0, NO_ITEM},
        '{8'h7F, 1'b0, NO_ITEM},
        '{8'h9F, 1'b0, NO_ITEM},
        '{{1'b1, 3'b000, OP_BINARY}, 1'b0, NO_ITEM},
        '{{1'b0, LEN_CODE_16}, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, NO_ITEM},
        '{8'h03, 1'b0, NO_ITEM},
        '{8'h11, 1'b0, NO_ITEM},
        '{8'h22, 1'b0, NO_ITEM},
        '{8'h33, 1'b0, NO_ITEM},
        '{{1'b0, 3'b000, OP_BINARY}, 1'b0, NO_ITEM},
        '{{1'b0, LEN_CODE_16}, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, NO_ITEM},
        '{8'h00, 1'b1, '{8'h00, KIND_EMPTY, OP_BINARY, 1'b0, 1'b1}},
        '{{1'b1, 3'b000, OP_CLOSE}, 1'b0, NO_ITEM},
        '{{1'b1, LEN_CODE_64}, 1'b1, '{8'h00, KIND_ERROR, OP_CLOSE, 1'b1, 1'b1}},
        '{8'h81, 1'b0, NO_ITEM},
        '{8'h05, 1'b0, NO_ITEM},
        '{8'hFF, 1'b0, NO_ITEM}
    };

    function automatic logic header_done(output frame_item_t res);
        rx_key_idx = 2'd0;
        res = NO_ITEM;
        if (rx_remaining == 16'h0000) begin
            rx_phase = PH_HDR0;
            res = '{8'h00, KIND_EMPTY, rx_opcode, rx_fin, 1'b1};
            return 1'b1;
        end
        rx_phase = PH_DATA;
        return 1'b0;
    endfunction

    // The length is known; a masked frame still has its key to read.
    function automatic logic length_done(output frame_item_t res);
        res = NO_ITEM;
        if (rx_masked) begin
            rx_key_idx = 2'd0;
            rx_phase = PH_MASK;
            return 1'b0;
        end
        return header_done(res);
    endfunction

    function automatic logic deframe_byte(input logic [7:0] b, output frame_item_t res);
        logic       hit;
        logic [7:0] d;
        hit = 1'b0;
        res = NO_ITEM;
        case (rx_phase)
            PH_HDR0: begin
                rx_fin = b[7];
                rx_opcode = b[3:0];
                rx_phase = PH_HDR1;
            end
            PH_HDR1: begin
                rx_masked = b[7];
                if (b[6:0] == LEN_CODE_64) begin
                    rx_phase = PH_DEAD;
                    res = '{8'h00, KIND_ERROR, rx_opcode, rx_fin, 1'b1};
                    hit = 1'b1;
                end else if (b[6:0] == LEN_CODE_16) begin
                    rx_phase = PH_EXTHI;
                end else begin
                    rx_remaining = {9'd0, b[6:0]};
                    hit = length_done(res);
                end
            end
            PH_EXTHI: begin
                rx_remaining = {b, 8'h00};
                rx_phase = PH_EXTLO;
            end
            PH_EXTLO: begin
                rx_remaining[7:0] = b;
                hit = length_done(res);
            end
            PH_MASK: begin
                rx_key[rx_key_idx] = b;
                rx_key_idx = rx_key_idx + 2'd1;
                if (rx_key_idx == 2'd0) hit = header_done(res);
            end
            PH_DATA: begin
                d = rx_masked ? (b ^ rx_key[rx_key_idx]) : b;
                rx_key_idx = rx_key_idx + 2'd1;
                rx_remaining = rx_remaining - 16'd1;
                if (rx_remaining == 16'h0000) rx_phase = PH_HDR0;
                res = '{d, KIND_DATA, rx_opcode, rx_fin, rx_remaining == 16'h0000};
                hit = 1'b1;
            end
            default: ;
        endcase
        return hit;
    endfunction

    // Called at a falling edge; returns at a falling edge with s_tvalid still high,
    // so back-to-back items never lower and raise it in the same step.
    task automatic push_byte(input logic [7:0] b, input logic typed, input frame_item_t want);
        frame_item_t res;
        logic        hit;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        hit = deframe_byte(b, res);
        if (typed) deframed_q.push_back(want);
        else if (hit) deframed_q.push_back(res);
        n_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [15:0] len, input logic masked, input logic ext);
        int unsigned i;
        push_byte(8'($urandom), 1'b0, NO_ITEM);
        if (ext || len > 16'd125) begin
            push_byte({masked, LEN_CODE_16}, 1'b0, NO_ITEM);
            push_byte(len[15:8], 1'b0, NO_ITEM);
            push_byte(len[7:0], 1'b0, NO_ITEM);
        end else begin
            push_byte({masked, len[6:0]}, 1'b0, NO_ITEM);
        end
        if (masked) repeat (KEY_BYTES) push_byte(8'($urandom), 1'b0, NO_ITEM);
        for (i = 0; i < len; i++) push_byte(8'($urandom), 1'b0, NO_ITEM);
        n_frames++;
    endtask

    // Raw bytes, then whatever it takes to close the frame they opened. The 64-bit
    // length code is steered away and extended lengths stay under 256.
    task automatic send_noise(input int unsigned count);
        int unsigned i;
        logic [7:0]  b;
        i = 0;
        while (i < count || rx_phase != PH_HDR0) begin
            b = 8'($urandom);
            if (rx_phase == PH_HDR1 && b[6:0] == LEN_CODE_64) b[6:0] = LEN_CODE_16;
            if (rx_phase == PH_EXTHI) b = 8'h00;
            push_byte(b, 1'b0, NO_ITEM);
            i++;
        end
    endtask

    task automatic run_random(input int unsigned n_target);
        int unsigned start;
        int unsigned pick;
        logic [15:0] len;
        start = n_bytes;
        while (n_bytes - start < n_target) begin
            if ($urandom_range(99) < 10) begin
                send_noise($urandom_range(12, 1));
            end else begin
                pick = $urandom_range(99);
                if (pick < 15) len = 16'd0;
                else if (pick < 75) len = 16'($urandom_range(12, 1));
                else if (pick < 90) len = 16'($urandom_range(125, 13));
                else len = 16'($urandom_range(300, 0));
                send_frame(len, $urandom_range(99) < 70, pick >= 90);
            end
        end
    endtask

    // Hold the input low until the block has handed out everything it owes.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        frame_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (deframed_q.size() == 0) begin
                $error("unexpected result item: m_tdata %h, m_tuser %0d", m_tdata, m_tuser);
                n_fail++;
            end else begin
                want = deframed_q.pop_front();
                if (want.kind == KIND_EMPTY) n_empty++;
                if (m_tdata[7:0] !== want.data) begin
                    $error("data_byte: expected %h, got %h", want.data, m_tdata[7:0]);
                    n_fail++;
                end
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    n_fail++;
                end
                if (m_tdata[11:8] !== want.opcode) begin
                    $error("frame_opcode: expected %h, got %h", want.opcode, m_tdata[11:8]);
                    n_fail++;
                end
                if (m_tdata[12] !== want.fin) begin
                    $error("final_frame: expected %b, got %b", want.fin, m_tdata[12]);
                    n_fail++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_byte: expected %b, got %b", want.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned i;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct = 28;
        sink_idle_pct = 65;
        for (i = 0; i < DIR_MAIN; i++) begin
            push_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
        end
        run_random(160);
        drain_outputs();

        src_idle_pct = 65;
        sink_idle_pct = 28;
        run_random(160);
        drain_outputs();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random(160);

        // The 64-bit length error kills the block until reset, so it comes last.
        for (i = DIR_MAIN; i < DIR_ROWS; i++) begin
            push_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
        end
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bytes (%0d random frames plus noise and directed rows)", n_bytes,
                 n_frames);
        $display("checked %0d result items, %0d empty frames, ending on the 64-bit length error",
                 n_results, n_empty);
        if (n_fail == 0 && deframed_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
